// File: rtl/core/trle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared widths, register indexes and the pixel record that passes from the
// front decoder through the queue to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package trle_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RUN_LENGTH_MODE = 2'd0,
        REG_BYTES_PER_PIXEL = 2'd1,
        REG_TOTAL_PIXELS    = 2'd2
    } cfg_reg_t;

    // Register widths and reset values
    localparam int BPP_W   = 3;
    localparam int COUNT_W = 25;

    localparam logic               RESET_RUN_LENGTH_MODE = 1'b1;
    localparam logic [BPP_W-1:0]   RESET_BYTES_PER_PIXEL = 3'd4;
    localparam logic [COUNT_W-1:0] RESET_TOTAL_PIXELS    = 25'd65536;

    // Three-byte pixel code and header fields
    localparam logic [BPP_W-1:0] BPP_THREE    = 3'd3;
    localparam logic [7:0]       RUN_BIAS     = 8'd127;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One finished pixel as the front hands it over
    typedef struct packed {
        logic [23:0] pixel_bytes;   // B in 7:0, G in 15:8, R in 23:16
        logic [7:0]  last_byte;     // byte that closed the pixel
        logic        short_pixel;   // three-byte pixel: last byte is red
        logic [7:0]  repeat_count;
        logic        image_end;
    } pix_t;

endpackage

`default_nettype wire

// File: rtl/core/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Turns TGA pixel-data bytes into RGBA pixels with a repeat count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / data_byte) takes one byte of pixel
//   data per transfer, one transfer per cycle when not stalled. Header bytes
//   of RLE packets and the leading bytes of a pixel give no result.
//   Output channel (out_valid / out_stall / red ... image_end) gives one
//   pixel per transfer; a run comes out once with its repeat_count, clipped
//   to the pixels left in the image. image_end marks the last result.
//   The transfer of a pixel's last byte writes it into the queue; from the head
//   of the queue it is loaded into the output register once that is free.
//   Throughput: one byte per cycle while in_stall is low, set by the front decoder.
//   A two-entry queue sits between front and output register; in_stall rises
//   only while that queue is full, so a stalled receiver holds back the input
//   after two more pixels. The output holds its payload while stalled.
//   Reset clears the decoder state and loads the configuration defaults:
//   RLE mode, four-byte pixels, 65536 pixels per image.
//   Configuration is written through cfg_write_en / cfg_index / cfg_data
//   while the block is idle; total_pixels takes effect at the next image.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write_en,
    input  wire  [trle_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [trle_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  [7:0]                           data_byte,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue,
    output logic [7:0]                           alpha,
    output logic [7:0]                           repeat_count,
    output logic                                 image_end
);

    logic                               accept;
    logic                               push;
    logic                               pop;
    logic                               queue_empty;
    logic                               queue_full;
    logic [trle_pkg::QUEUE_CW-1:0]      queue_level;
    trle_pkg::pix_t                     push_pix;
    trle_pkg::pix_t                     head_pix;

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // Front: configuration, header decode, byte assembly, image count
    trle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .push         (push),
        .push_pix     (push_pix)
    );

    // Queue between front and output stage
    trle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pix (push_pix),
        .pop      (pop),
        .head_pix (head_pix),
        .empty    (queue_empty),
        .full     (queue_full),
        .level    (queue_level)
    );

    // Output stage
    trle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_pix     (head_pix),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .repeat_count (repeat_count),
        .image_end    (image_end)
    );

    // Queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= trle_pkg::QUEUE_CW'(trle_pkg::QUEUE_DEPTH))
        else $error("pixel queue over depth");

    // A delivered result never carries a zero repeat count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> repeat_count != 8'd0)
        else $error("zero repeat count on output");

    // A completed output transfer is refilled next cycle when pixels wait
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !queue_empty |=> out_valid)
        else $error("output stage idle with queued pixels");

    // A pushed pixel leaves the queue non-empty or goes straight out
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !queue_empty || out_valid)
        else $error("pushed pixel lost");

endmodule

`default_nettype wire

// File: rtl/core/trle_front.sv
// ----------------------------------------------------------------------------
// TGA RLE front decoder
// Holds the configuration, takes one data byte per transfer, decodes packet
// headers, assembles pixel bytes and counts the image, pushing finished pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_front (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write_en,
    input  wire  [trle_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [trle_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                  accept,
    input  wire  [7:0]                           data_byte,
    output logic                                 push,
    output trle_pkg::pix_t                       push_pix
);

    // Configuration registers
    logic                           mode_reg;
    logic [trle_pkg::BPP_W-1:0]     bpp_reg;
    logic [trle_pkg::COUNT_W-1:0]   total_reg;

    // Decode state
    logic [7:0]                     packet_left_reg, packet_left_next;
    logic                           is_run_reg, is_run_next;
    logic [1:0]                     pos_reg, pos_next;
    logic [23:0]                    pixel_reg, pixel_next;
    logic [trle_pkg::COUNT_W-1:0]   remain_reg, remain_next;

    logic [trle_pkg::COUNT_W-1:0]   remain_eff;
    logic [trle_pkg::COUNT_W-1:0]   rep_wide;
    logic [trle_pkg::COUNT_W-1:0]   remain_after;
    logic [1:0]                     last_pos;
    logic [7:0]                     rep;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= trle_pkg::RESET_RUN_LENGTH_MODE;
            bpp_reg   <= trle_pkg::RESET_BYTES_PER_PIXEL;
            total_reg <= trle_pkg::RESET_TOTAL_PIXELS;
        end
        else if (cfg_write_en)
        begin
            case (trle_pkg::cfg_reg_t'(cfg_index))
                trle_pkg::REG_RUN_LENGTH_MODE: mode_reg  <= cfg_data[0];
                trle_pkg::REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_data[trle_pkg::BPP_W-1:0];
                trle_pkg::REG_TOTAL_PIXELS:    total_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Byte decode
    always_comb
    begin
        packet_left_next = packet_left_reg;
        is_run_next      = is_run_reg;
        pos_next         = pos_reg;
        pixel_next       = pixel_reg;
        remain_next      = remain_reg;
        push             = 1'b0;
        rep              = 8'd1;
        rep_wide         = '0;
        remain_after     = remain_reg;

        // image start reload, zero total counts as one pixel
        if (remain_reg == '0)
            remain_eff = (total_reg == '0) ? trle_pkg::COUNT_W'(1) : total_reg;
        else
            remain_eff = remain_reg;

        last_pos = (bpp_reg == trle_pkg::BPP_THREE) ? 2'd2 : 2'd3;

        if (accept)
        begin
            remain_next = remain_eff;
            if (mode_reg && packet_left_reg == 8'd0)
            begin
                // packet header
                is_run_next      = data_byte[7];
                packet_left_next = data_byte[7] ? (data_byte - trle_pkg::RUN_BIAS)
                                                : (data_byte + 8'd1);
            end
            else if (pos_reg < last_pos)
            begin
                // collect one colour byte
                case (pos_reg)
                    2'd0:    pixel_next[7:0]   = data_byte;
                    2'd1:    pixel_next[15:8]  = data_byte;
                    default: pixel_next[23:16] = data_byte;
                endcase
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                // pixel complete
                if (last_pos == 2'd2)
                    pixel_next[23:16] = data_byte;
                pos_next = 2'd0;
                push     = 1'b1;

                if (mode_reg)
                begin
                    if (is_run_reg)
                    begin
                        rep              = packet_left_reg;
                        packet_left_next = 8'd0;
                    end
                    else
                    begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                end

                // clip to what is left of the image
                rep_wide = {{(trle_pkg::COUNT_W-8){1'b0}}, rep};
                if (rep_wide > remain_eff)
                begin
                    rep      = remain_eff[7:0];
                    rep_wide = remain_eff;
                end
                remain_after = remain_eff - rep_wide;
                remain_next  = remain_after;

                // image end drops the packet in progress
                if (remain_after == '0)
                begin
                    packet_left_next = 8'd0;
                    is_run_next      = 1'b0;
                    pos_next         = 2'd0;
                end
            end
        end

        push_pix.pixel_bytes  = pixel_reg;
        push_pix.last_byte    = data_byte;
        push_pix.short_pixel  = (last_pos == 2'd2);
        push_pix.repeat_count = rep;
        push_pix.image_end    = (remain_after == '0);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_left_reg <= 8'd0;
            is_run_reg      <= 1'b0;
            pos_reg         <= 2'd0;
            pixel_reg       <= 24'd0;
            remain_reg      <= '0;
        end
        else
        begin
            packet_left_reg <= packet_left_next;
            is_run_reg      <= is_run_next;
            pos_reg         <= pos_next;
            pixel_reg       <= pixel_next;
            remain_reg      <= remain_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/trle_queue.sv
// ----------------------------------------------------------------------------
// TGA RLE pixel queue
// Short FIFO of finished pixels so the front and the output stage stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_queue (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  push,
    input  trle_pkg::pix_t                       push_pix,
    input  wire                                  pop,
    output trle_pkg::pix_t                       head_pix,
    output logic                                 empty,
    output logic                                 full,
    output logic [trle_pkg::QUEUE_CW-1:0]        level
);

    trle_pkg::pix_t                     entry_reg [trle_pkg::QUEUE_DEPTH];
    logic [trle_pkg::QUEUE_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [trle_pkg::QUEUE_CW-1:0]      count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == trle_pkg::QUEUE_CW'(trle_pkg::QUEUE_DEPTH));
    assign level    = count_reg;
    assign head_pix = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + trle_pkg::QUEUE_CW'(1);
        else if (pop && !push)
            count_next = count_reg - trle_pkg::QUEUE_CW'(1);
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == trle_pkg::QUEUE_AW'(trle_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + trle_pkg::QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == trle_pkg::QUEUE_AW'(trle_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + trle_pkg::QUEUE_AW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_pix;
    end

endmodule

`default_nettype wire

// File: rtl/core/trle_back.sv
// ----------------------------------------------------------------------------
// TGA RLE output stage
// Pulls pixels from the queue, resolves red and alpha for the pixel size and
// holds the result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trle_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  trle_pkg::pix_t      head_pix,
    input  wire                 queue_empty,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [7:0]          alpha,
    output logic [7:0]          repeat_count,
    output logic                image_end
);

    logic        valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, rep_reg;
    logic        end_reg;

    // Load when the register is empty or its transfer completes now
    assign pop = !queue_empty && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= !queue_empty;
    end

    // Payload, red and alpha depend on the pixel size
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            blue_reg  <= head_pix.pixel_bytes[7:0];
            green_reg <= head_pix.pixel_bytes[15:8];
            red_reg   <= head_pix.short_pixel ? head_pix.last_byte
                                              : head_pix.pixel_bytes[23:16];
            alpha_reg <= head_pix.short_pixel ? trle_pkg::ALPHA_OPAQUE
                                              : head_pix.last_byte;
            rep_reg   <= head_pix.repeat_count;
            end_reg   <= head_pix.image_end;
        end
    end

    assign out_valid    = valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign repeat_count = rep_reg;
    assign image_end    = end_reg;

endmodule

`default_nettype wire

// File: verif/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds pixel-data bytes through the input channel and checks every pixel
// transfer against a cycle-free decoder kept in a small scoreboard class.
// A short directed sequence covers header extremes, run clipping, image end,
// odd pixel sizes and a size change mid-pixel; random phases follow, each
// with a fresh register setting, mostly well-formed packets plus noise.
// ----------------------------------------------------------------------------

module testbench;

    localparam int     CLK_HALF_NS     = 5;
    localparam int     RANDOM_BYTES    = 1350;
    localparam int     SETTLE_CYCLES   = 6;
    localparam int     END_WAIT_CYCLES = 20000;
    localparam longint RUN_LIMIT_NS    = 3000000;

    localparam logic [trle_pkg::COUNT_W-1:0] MAX_TOTAL = 25'd16777216;

    // One decoded pixel as seen on the output channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_end;
    } pixel_result_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    // ------------------------------------------------------------------------
    // Decoder tracker: mirrors the block's state, queues the pixels it must
    // produce and checks each output transfer against the oldest one.
    // ------------------------------------------------------------------------
    class rle_pixel_tracker;
        logic                           rle_mode;
        logic [trle_pkg::BPP_W-1:0]     bpp;
        logic [trle_pkg::COUNT_W-1:0]   total;
        logic [7:0]                     packet_left;
        logic                           is_run;
        logic [1:0]                     byte_pos;
        logic [23:0]                    pixel;
        logic [trle_pkg::COUNT_W-1:0]   remaining;
        pixel_result_t                  pending_pixels[$];
        int                             error_count;

        function new();
            rle_mode    = trle_pkg::RESET_RUN_LENGTH_MODE;
            bpp         = trle_pkg::RESET_BYTES_PER_PIXEL;
            total       = trle_pkg::RESET_TOTAL_PIXELS;
            packet_left = '0;
            is_run      = 1'b0;
            byte_pos    = '0;
            pixel       = '0;
            remaining   = '0;
            error_count = 0;
        endfunction

        function void write_register(trle_pkg::cfg_reg_t idx,
                                     logic [trle_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                trle_pkg::REG_RUN_LENGTH_MODE: rle_mode = value[0];
                trle_pkg::REG_BYTES_PER_PIXEL: bpp      = value[trle_pkg::BPP_W-1:0];
                trle_pkg::REG_TOTAL_PIXELS:    total    = value[trle_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Decode one accepted byte; queue a pixel when one completes
        function void take_byte(logic [7:0] b);
            logic [1:0]                     last_pos;
            logic [7:0]                     alpha_val;
            logic [trle_pkg::COUNT_W-1:0]   rep;
            pixel_result_t                  px;

            last_pos = (bpp == trle_pkg::BPP_THREE) ? 2'd2 : 2'd3;

            // new image opens on the first byte; zero size means one pixel
            if (remaining == 0)
                remaining = (total == 0) ? trle_pkg::COUNT_W'(1) : total;

            // packet header
            if (rle_mode && packet_left == 0)
            begin
                is_run      = b[7];
                packet_left = b[7] ? (b - trle_pkg::RUN_BIAS) : (b + 8'd1);
                return;
            end

            // leading bytes of a pixel
            if (byte_pos < last_pos)
            begin
                pixel[int'(byte_pos) * 8 +: 8] = b;
                byte_pos = byte_pos + 2'd1;
                return;
            end

            // closing byte: red for short pixels, alpha otherwise
            if (last_pos == 2'd2)
            begin
                pixel[23:16] = b;
                alpha_val    = trle_pkg::ALPHA_OPAQUE;
            end
            else
                alpha_val = b;
            byte_pos = '0;

            rep = trle_pkg::COUNT_W'(1);
            if (rle_mode)
            begin
                if (is_run)
                begin
                    rep         = trle_pkg::COUNT_W'(packet_left);
                    packet_left = '0;
                end
                else
                    packet_left = packet_left - 8'd1;
            end
            // clip to what is left of the image
            if (rep > remaining)
                rep = remaining;
            remaining = remaining - rep;

            px.image_end = (remaining == 0);
            if (px.image_end)
            begin
                packet_left = '0;
                is_run      = 1'b0;
                byte_pos    = '0;
            end

            px.red          = pixel[23:16];
            px.green        = pixel[15:8];
            px.blue         = pixel[7:0];
            px.alpha        = alpha_val;
            px.repeat_count = rep[7:0];
            pending_pixels.push_back(px);
        endfunction

        function void report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            error_count++;
        endfunction

        function void compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%02h, want 0x%02h", name, got, want));
        endfunction

        function void check_pixel(pixel_result_t got);
            pixel_result_t want;

            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel with no expectation: %p", got));
                return;
            end
            want = pending_pixels.pop_front();
            compare_field("red", got.red, want.red);
            compare_field("green", got.green, want.green);
            compare_field("blue", got.blue, want.blue);
            compare_field("alpha", got.alpha, want.alpha);
            compare_field("repeat_count", got.repeat_count, want.repeat_count);
            compare_field("image_end", 8'(got.image_end), 8'(want.image_end));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               cfg_write_en = 1'b0;
    logic [trle_pkg::CFG_INDEX_W-1:0]   cfg_index    = trle_pkg::REG_RUN_LENGTH_MODE;
    logic [trle_pkg::CFG_DATA_W-1:0]    cfg_data     = '0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    logic [7:0]                         data_byte    = '0;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic [7:0]                         red;
    logic [7:0]                         green;
    logic [7:0]                         blue;
    logic [7:0]                         alpha;
    logic [7:0]                         repeat_count;
    logic                               image_end;

    rle_pixel_tracker tracker;
    int               burst_left = 0;
    int               bytes_sent = 0;
    int unsigned      stall_tick = 0;
    stall_style_t     stall_style = STALL_NONE;

    tga_rle_pixel_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .repeat_count (repeat_count),
        .image_end    (image_end)
    );

    always #CLK_HALF_NS clk = ~clk;

    // Monitors: byte transfers feed the tracker, pixel transfers are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_byte(data_byte);
            if (out_valid && !out_stall)
                tracker.check_pixel(pixel_result_t'{red, green, blue, alpha,
                                                    repeat_count, image_end});
        end
    end

    // Receiver stall pattern with a randomly redrawn style
    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 128 == 0)
            stall_style = stall_style_t'($urandom_range(0, 3));
        case (stall_style)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
            default:     out_stall <= ((stall_tick % 7) < 4);
        endcase
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // One byte transfer; the sender runs in bursts with random gaps
    task automatic send_byte(input logic [7:0] value);
        int gap;

        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3, 4, 5, 6, 7: gap = $urandom_range(1, 3);
                default: gap = $urandom_range(4, 12);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 10);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Hold off until every queued pixel has come out, then let the block settle
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes back to back; only the size register when size_only
    task automatic configure(input logic mode, input logic [trle_pkg::BPP_W-1:0] bpp,
                             input logic [trle_pkg::COUNT_W-1:0] total,
                             input bit size_only);
        trle_pkg::cfg_reg_t                 regs[3];
        logic [trle_pkg::CFG_DATA_W-1:0]    values[3];
        int                                 first;

        regs[0]   = trle_pkg::REG_RUN_LENGTH_MODE;
        regs[1]   = trle_pkg::REG_BYTES_PER_PIXEL;
        regs[2]   = trle_pkg::REG_TOTAL_PIXELS;
        values[0] = trle_pkg::CFG_DATA_W'(mode);
        values[1] = trle_pkg::CFG_DATA_W'(bpp);
        values[2] = trle_pkg::CFG_DATA_W'(total);
        first     = size_only ? 2 : 0;
        cfg_write_en <= 1'b1;
        for (int i = first; i < 3; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= values[i];
            @(posedge clk);
            tracker.write_register(regs[i], values[i]);
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_pixel();
        int n;

        n = (tracker.bpp == trle_pkg::BPP_THREE) ? 3 : 4;
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // One random stimulus unit: packets, plain pixels, noise or a broken pixel
    task automatic random_unit();
        int r;
        int n;

        r = $urandom_range(0, 99);
        if (r < 3)
            wait_idle();
        else if (!tracker.rle_mode)
        begin
            if (r < 90)
                send_pixel();
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 55)
        begin
            // run packet
            n = $urandom_range(0, 1) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            send_byte(8'(127 + n));
            send_pixel();
        end
        else if (r < 85)
        begin
            // raw packet, mostly short
            case ($urandom_range(0, 49))
                0:             n = $urandom_range(1, 128);
                1, 2, 3, 4:    n = $urandom_range(5, 20);
                default:       n = $urandom_range(1, 4);
            endcase
            send_byte(8'(n - 1));
            repeat (n) send_pixel();
        end
        else if (r < 95)
            send_byte(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                             phase_end;
        int                             target;
        int                             waited;
        logic                           mode;
        logic [trle_pkg::BPP_W-1:0]     bpp;
        logic [trle_pkg::COUNT_W-1:0]   total;

        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode and size, small image: single run, then a run clipped at image end
        configure(1'b0, '0, 25'd3, 1'b1);
        send_byte(8'h80);
        repeat (4) send_byte(8'h00);
        send_byte(8'hFF);
        repeat (4) send_byte(8'hFF);

        // Three-byte pixels: raw packet overrunning the image, then a long run
        wait_idle();
        configure(1'b1, trle_pkg::BPP_THREE, 25'd3, 1'b0);
        send_byte(8'h04);
        repeat (3)
        begin
            send_byte(8'h55);
            send_byte(8'hAA);
            send_byte(8'h5A);
        end
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);

        // Plain mode, odd size code, zero-pixel image taken as one pixel
        wait_idle();
        configure(1'b0, 3'd7, 25'd0, 1'b0);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);

        // Size change mid-pixel: three bytes held, header, then one closing byte
        send_byte(8'h9A);
        send_byte(8'hBC);
        send_byte(8'hDE);
        wait_idle();
        configure(1'b1, trle_pkg::BPP_THREE, 25'd2, 1'b0);
        send_byte(8'h81);
        send_byte(8'hF0);

        // Random phases, each with a new register setting
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            wait_idle();
            mode = ($urandom_range(0, 99) < 75);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: bpp = trle_pkg::BPP_THREE;
                4, 5, 6, 7: bpp = 3'd4;
                default:    bpp = trle_pkg::BPP_W'($urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 9))
                0:          total = '0;
                1, 2:       total = trle_pkg::COUNT_W'($urandom_range(41, 200));
                default:    total = trle_pkg::COUNT_W'($urandom_range(1, 40));
            endcase
            configure(mode, bpp, total, 1'b0);
            phase_end = bytes_sent + $urandom_range(60, 200);
            while (bytes_sent < phase_end && bytes_sent < target)
                random_unit();
        end

        // Image size of 2^24 pixels last, since such an image never completes here
        wait_idle();
        configure(1'b1, 3'd4, MAX_TOTAL, 1'b0);
        repeat (10) random_unit();

        // Drain and finish
        in_valid <= 1'b0;
        waited = 0;
        while (tracker.pending_pixels.size() != 0 && waited < END_WAIT_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_pixels.size() != 0)
            tracker.report_mismatch($sformatf("%0d expected pixels never arrived",
                                              tracker.pending_pixels.size()));
        if (tracker.error_count == 0)
            $display("tga_rle_pixel_decoder verification clean");
        else
            $display("tga_rle_pixel_decoder verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tga_rle_pixel_decoder verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/trle_pkg.sv
rtl/core/trle_front.sv
rtl/core/trle_queue.sv
rtl/core/trle_back.sv
rtl/core/tga_rle_pixel_decoder.sv
verif/tga_rle_pixel_decoder_tb.sv
